// ===== src/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue block.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int DATA_W = 32;

  // request codes; anything above REQ_PEEK behaves as a peek
  localparam logic [2:0] REQ_PUSH_LEFT  = 3'd0;
  localparam logic [2:0] REQ_PUSH_RIGHT = 3'd1;
  localparam logic [2:0] REQ_POP_LEFT   = 3'd2;
  localparam logic [2:0] REQ_POP_RIGHT  = 3'd3;
  localparam logic [2:0] REQ_PEEK       = 3'd4;

  localparam logic [1:0] STS_DONE       = 2'd0;
  localparam logic [1:0] STS_POP_EMPTY  = 2'd1;
  localparam logic [1:0] STS_PUSH_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_READ,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic read;
    logic load;
  } dq_cmd_t;

  typedef struct packed {
    logic out_free;
  } dq_sts_t;

endpackage

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: ring-buffer deque of 16 signed 32-bit values.
// One request at a time; update, memory-read and load steps follow a capture.
// Load waits on a stalled output; the output register then frees the input.
// Reset clears end pointer, count and output valid; slot contents undefined.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] left_value_o,
  output logic signed [31:0] right_value_o,
  output logic               is_empty_o,
  output logic [4:0]         occupancy_o
);
  import dq_pkg::*;

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .left_value_o  (left_value_o),
    .right_value_o (right_value_o),
    .is_empty_o    (is_empty_o),
    .occupancy_o   (occupancy_o)
  );

endmodule

// ===== src/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: capture a request, update the ring, read both ends, load result.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  dq_pkg::dq_sts_t sts_i,
  output dq_pkg::dq_cmd_t cmd_o
);
  import dq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_READ;
      ST_READ:   state_d = ST_LOAD;
      ST_LOAD: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_READ:   cmd_o.read   = 1'b1;
      ST_LOAD:   cmd_o.load   = sts_i.out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// dq_datapath
// Ring storage, end pointer, entry count and the output register.
// ----------------------------------------------------------------------------
module dq_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dq_pkg::dq_cmd_t            cmd_i,
  output dq_pkg::dq_sts_t            sts_o,
  input  logic [2:0]                 req_type_i,
  input  logic signed [31:0]         push_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic signed [31:0]         left_value_o,
  output logic signed [31:0]         right_value_o,
  output logic                       is_empty_o,
  output logic [4:0]                 occupancy_o
);
  import dq_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [2:0]               req_q;
  logic signed [DATA_W-1:0] val_q;
  logic [IDX_W-1:0]         left_q, left_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [1:0]               sts_q, sts_d;
  logic signed [DATA_W-1:0] rd_left_q, rd_right_q;
  logic                     out_valid_q;

  logic                     full, empty;
  logic [IDX_W-1:0]         left_prev, left_next, tail_pos, right_pos;
  logic [SUM_W-1:0]         tail_sum, right_sum;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;

  assign full  = (cnt_q == CNT_W'(DEPTH));
  assign empty = (cnt_q == '0);

  assign left_prev = (left_q == '0) ? IDX_W'(DEPTH - 1) : left_q - 1'b1;
  assign left_next = (left_q == IDX_W'(DEPTH - 1)) ? '0 : left_q + 1'b1;

  // slot just past the right end; count is below DEPTH here
  assign tail_sum = SUM_W'(left_q) + SUM_W'(cnt_q);
  assign tail_pos = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(tail_sum);
  // right end, only meaningful with at least one entry
  assign right_sum = tail_sum - 1'b1;
  assign right_pos = empty ? left_q
                   : (right_sum >= SUM_W'(DEPTH)) ? IDX_W'(right_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(right_sum);

  always_comb begin
    left_d  = left_q;
    cnt_d   = cnt_q;
    sts_d   = STS_DONE;
    wr_en   = 1'b0;
    wr_addr = tail_pos;
    case (req_q)
      REQ_PUSH_LEFT: begin
        if (full) begin
          sts_d = STS_PUSH_FULL;
        end else begin
          left_d  = left_prev;
          wr_addr = left_prev;
          wr_en   = 1'b1;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      REQ_PUSH_RIGHT: begin
        if (full) begin
          sts_d = STS_PUSH_FULL;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      REQ_POP_LEFT: begin
        if (empty) begin
          sts_d = STS_POP_EMPTY;
        end else begin
          left_d = left_next;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      REQ_POP_RIGHT: begin
        if (empty) begin
          sts_d = STS_POP_EMPTY;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        sts_d = STS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.update) begin
      left_q <= left_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      val_q <= push_value_i;
    end
    if (cmd_i.update) sts_q <= sts_d;
  end

  // ring memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && wr_en) mem[wr_addr] <= val_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_left_q  <= mem[left_q];
      rd_right_q <= mem[right_pos];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_o      <= sts_q;
      left_value_o  <= empty ? '0 : rd_left_q;
      right_value_o <= empty ? '0 : rd_right_q;
      is_empty_o    <= empty;
      occupancy_o   <= 5'(cnt_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule
